@@ src/fba_pkg.sv @@
// Package for the frame bitmap allocator: request, status and sequencer codes,
// the word-unit operation code and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int FRAME_W = 20;
  localparam int BASE_W  = FRAME_W + 1;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_TEST    = 2'd2,
    REQ_RESERVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MAPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LOCATE,
    S_ACCESS,
    S_RESPOND
  } fsm_t;

  typedef enum logic [1:0] {
    WOP_FIND,
    WOP_SET,
    WOP_CLEAR
  } wop_t;

  typedef struct packed {
    logic found;
    logic hit;
  } wu_stat_t;

endpackage

@@ src/fba_if.sv @@
// Request and response channel interfaces of the frame bitmap allocator.
// Depends on fba_pkg for the field widths.
`timescale 1ns / 1ps

interface fba_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [fba_pkg::FRAME_W-1:0] frame_index;
  logic                        supervisor;
  logic                        write_perm;

  modport source (output valid, req_type, frame_index, supervisor, write_perm,
                  input ready);
  modport sink (input valid, req_type, frame_index, supervisor, write_perm,
                output ready);
endinterface

interface fba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fba_pkg::FRAME_W-1:0] frame_out;
  logic                        present;
  logic                        user_mode;
  logic                        writable;
  logic                        in_use;

  modport source (output valid, status, frame_out, present, user_mode, writable, in_use,
                  input ready);
  modport sink (input valid, status, frame_out, present, user_mode, writable, in_use,
                output ready);
endinterface

@@ src/fba_ram.sv @@
// Bitmap word memory: one write port and one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fba_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/fba_word_unit.sv @@
// Shared bitmap word unit: finds the lowest free bit, sets or clears one bit,
// and reads one bit. Depends on fba_pkg.
`timescale 1ns / 1ps

module fba_word_unit #(
  parameter int WORD_BITS = 32,
  parameter int LAST_BITS = 32,
  parameter int BW        = 5
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 last,
  input  logic [BW-1:0]        bit_idx,
  input  fba_pkg::wop_t        op,
  output logic [WORD_BITS-1:0] new_word,
  output logic [BW-1:0]        free_idx,
  output fba_pkg::wu_stat_t    stat
);

  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  logic [WORD_BITS-1:0] filled;
  logic [WORD_BITS-1:0] lowest;
  logic [WORD_BITS-1:0] sel;

  // Bit positions of the last word past the last frame count as used.
  assign filled = last ? (word | ~LAST_MASK) : word;
  assign lowest = ~filled & (filled + 1'b1);
  assign sel    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_idx;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        free_idx = free_idx | BW'(i);
      end
    end
  end

  always_comb begin
    unique case (op)
      fba_pkg::WOP_FIND:  new_word = word | lowest;
      fba_pkg::WOP_SET:   new_word = word | sel;
      fba_pkg::WOP_CLEAR: new_word = word & ~sel;
      default:            new_word = word;
    endcase
  end

  assign stat.found = |lowest;
  assign stat.hit   = word[bit_idx];

endmodule

@@ src/frame_bitmap_allocator.sv @@
// Top level of the frame bitmap allocator: request sequencer, bitmap memory
// and shared word unit. Depends on fba_pkg, fba_if, fba_ram and fba_word_unit.
//
//   channel   port      direction  payload
//   request   in_chan   sink       req_type, frame_index, supervisor, write_perm
//   response  out_chan  source     status, frame_out, present, user_mode, writable, in_use
//
// After reset the bitmap is cleared one word per cycle, with in_chan not ready.
// An alloc reads one bitmap word per cycle from word zero up, until a word with a free frame
// is found or the last word is checked. An alloc on a mapped entry goes straight to the response.
// Free, test and reserve step a word counter up to the frame's word, then read it; free and
// reserve write it back. An out-of-range frame goes straight to the response.
// One request is in work at a time; a finished response waits in the output register.
`timescale 1ns / 1ps

module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input logic        clk,
  input logic        rst_n,
  fba_req_if.sink    in_chan,
  fba_rsp_if.source  out_chan
);

  localparam int FRAME_W   = fba_pkg::FRAME_W;
  localparam int BASE_W    = fba_pkg::BASE_W;
  localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST_BITS = NUM_FRAMES - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [AW-1:0]     LAST_W = AW'(NUM_WORDS - 1);
  localparam logic [BASE_W-1:0] NF     = BASE_W'(NUM_FRAMES);
  localparam logic [BASE_W-1:0] WB     = BASE_W'(WORD_BITS);

  fba_pkg::fsm_t state_r, state_nxt;
  logic [AW-1:0]     w_r, w_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_w_r, chk_w_nxt;
  logic [BASE_W-1:0] chk_base_r, chk_base_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;

  fba_pkg::req_t        op_r, op_nxt;
  logic [FRAME_W-1:0]   fi_r, fi_nxt;
  logic                 kern_r, kern_nxt;
  logic                 wr_r, wr_nxt;

  fba_pkg::status_t     res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]   res_frame_r, res_frame_nxt;
  logic                 res_present_r, res_present_nxt;
  logic                 res_user_r, res_user_nxt;
  logic                 res_wr_r, res_wr_nxt;
  logic                 res_used_r, res_used_nxt;

  logic                 out_valid_r, out_valid_nxt;
  fba_pkg::status_t     out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic                 out_present_r, out_present_nxt;
  logic                 out_user_r, out_user_nxt;
  logic                 out_wr_r, out_wr_nxt;
  logic                 out_used_r, out_used_nxt;

  logic                 in_xfer;
  fba_pkg::req_t        in_req;
  logic [BASE_W-1:0]    offset;
  logic [BASE_W-1:0]    found_frame;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 wu_last;
  fba_pkg::wop_t        wu_op;
  logic [WORD_BITS-1:0] wu_new;
  logic [BW-1:0]        wu_idx;
  fba_pkg::wu_stat_t    wu_stat;

  fba_ram #(
    .DEPTH (NUM_WORDS),
    .AW    (AW),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fba_word_unit #(
    .WORD_BITS (WORD_BITS),
    .LAST_BITS (LAST_BITS),
    .BW        (BW)
  ) u_word_unit (
    .word     (ram_rdata),
    .last     (wu_last),
    .bit_idx  (bit_r),
    .op       (wu_op),
    .new_word (wu_new),
    .free_idx (wu_idx),
    .stat     (wu_stat)
  );

  assign in_chan.ready = (state_r == fba_pkg::S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign in_req        = fba_pkg::req_t'(in_chan.req_type);
  assign offset        = {1'b0, fi_r} - base_r;
  assign found_frame   = chk_base_r + BASE_W'(wu_idx);
  assign wu_last       = (chk_w_r == LAST_W);
  assign ram_raddr     = w_r;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.frame_out = out_frame_r;
  assign out_chan.present   = out_present_r;
  assign out_chan.user_mode = out_user_r;
  assign out_chan.writable  = out_wr_r;
  assign out_chan.in_use    = out_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fba_pkg::S_CLEAR;
      w_r         <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r        <= base_nxt;
    chk_w_r       <= chk_w_nxt;
    chk_base_r    <= chk_base_nxt;
    bit_r         <= bit_nxt;
    op_r          <= op_nxt;
    fi_r          <= fi_nxt;
    kern_r        <= kern_nxt;
    wr_r          <= wr_nxt;
    res_status_r  <= res_status_nxt;
    res_frame_r   <= res_frame_nxt;
    res_present_r <= res_present_nxt;
    res_user_r    <= res_user_nxt;
    res_wr_r      <= res_wr_nxt;
    res_used_r    <= res_used_nxt;
    out_status_r  <= out_status_nxt;
    out_frame_r   <= out_frame_nxt;
    out_present_r <= out_present_nxt;
    out_user_r    <= out_user_nxt;
    out_wr_r      <= out_wr_nxt;
    out_used_r    <= out_used_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    w_nxt           = w_r;
    base_nxt        = base_r;
    chk_vld_nxt     = chk_vld_r;
    chk_w_nxt       = chk_w_r;
    chk_base_nxt    = chk_base_r;
    bit_nxt         = bit_r;
    op_nxt          = op_r;
    fi_nxt          = fi_r;
    kern_nxt        = kern_r;
    wr_nxt          = wr_r;
    res_status_nxt  = res_status_r;
    res_frame_nxt   = res_frame_r;
    res_present_nxt = res_present_r;
    res_user_nxt    = res_user_r;
    res_wr_nxt      = res_wr_r;
    res_used_nxt    = res_used_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_status_nxt  = out_status_r;
    out_frame_nxt   = out_frame_r;
    out_present_nxt = out_present_r;
    out_user_nxt    = out_user_r;
    out_wr_nxt      = out_wr_r;
    out_used_nxt    = out_used_r;
    ram_we          = 1'b0;
    ram_waddr       = w_r;
    ram_wdata       = wu_new;
    wu_op           = fba_pkg::WOP_FIND;

    unique case (state_r)
      fba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        w_nxt     = w_r + 1'b1;
        if (w_r == LAST_W) begin
          w_nxt     = '0;
          state_nxt = fba_pkg::S_IDLE;
        end
      end

      fba_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_nxt          = in_req;
          fi_nxt          = in_chan.frame_index;
          kern_nxt        = in_chan.supervisor;
          wr_nxt          = in_chan.write_perm;
          w_nxt           = '0;
          base_nxt        = '0;
          chk_vld_nxt     = 1'b0;
          res_status_nxt  = fba_pkg::ST_OK;
          res_frame_nxt   = in_chan.frame_index;
          res_present_nxt = 1'b0;
          res_user_nxt    = 1'b0;
          res_wr_nxt      = 1'b0;
          res_used_nxt    = 1'b0;
          if (in_req == fba_pkg::REQ_ALLOC) begin
            if (in_chan.frame_index != '0) begin
              res_status_nxt = fba_pkg::ST_MAPPED;
              state_nxt      = fba_pkg::S_RESPOND;
            end else begin
              state_nxt = fba_pkg::S_SCAN;
            end
          end else if ({1'b0, in_chan.frame_index} >= NF) begin
            res_status_nxt = fba_pkg::ST_RANGE;
            state_nxt      = fba_pkg::S_RESPOND;
          end else begin
            state_nxt = fba_pkg::S_LOCATE;
          end
        end
      end

      fba_pkg::S_SCAN: begin
        // Read data always belongs to the checked word, whose address was read in the cycle before.
        chk_vld_nxt  = 1'b1;
        chk_w_nxt    = w_r;
        chk_base_nxt = base_r;
        if (w_r != LAST_W) begin
          w_nxt    = w_r + 1'b1;
          base_nxt = base_r + WB;
        end
        if (chk_vld_r) begin
          if (wu_stat.found) begin
            ram_we          = 1'b1;
            ram_waddr       = chk_w_r;
            res_frame_nxt   = found_frame[FRAME_W-1:0];
            res_present_nxt = 1'b1;
            res_user_nxt    = !kern_r;
            res_wr_nxt      = wr_r;
            state_nxt       = fba_pkg::S_RESPOND;
          end else if (chk_w_r == LAST_W) begin
            res_status_nxt = fba_pkg::ST_FULL;
            res_frame_nxt  = '0;
            state_nxt      = fba_pkg::S_RESPOND;
          end
        end
      end

      fba_pkg::S_LOCATE: begin
        if (offset < WB) begin
          bit_nxt   = offset[BW-1:0];
          state_nxt = fba_pkg::S_ACCESS;
        end else begin
          w_nxt    = w_r + 1'b1;
          base_nxt = base_r + WB;
        end
      end

      fba_pkg::S_ACCESS: begin
        unique case (op_r)
          fba_pkg::REQ_FREE: begin
            wu_op         = fba_pkg::WOP_CLEAR;
            ram_we        = 1'b1;
            res_frame_nxt = '0;
          end
          fba_pkg::REQ_RESERVE: begin
            wu_op  = fba_pkg::WOP_SET;
            ram_we = 1'b1;
          end
          fba_pkg::REQ_TEST: begin
            res_used_nxt = wu_stat.hit;
          end
          default: begin
            wu_op = fba_pkg::WOP_FIND;
          end
        endcase
        state_nxt = fba_pkg::S_RESPOND;
      end

      fba_pkg::S_RESPOND: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_frame_nxt   = res_frame_r;
          out_present_nxt = res_present_r;
          out_user_nxt    = res_user_r;
          out_wr_nxt      = res_wr_r;
          out_used_nxt    = res_used_r;
          state_nxt       = fba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fba_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == fba_pkg::S_CLEAR || state_r == fba_pkg::S_SCAN ||
                state_r == fba_pkg::S_ACCESS))
    else $error("Bitmap written outside clear, scan or access.");

  a_locate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fba_pkg::S_LOCATE) |-> ({1'b0, fi_r} < NF))
    else $error("Word search started for an out-of-range frame.");

  a_alloc_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req == fba_pkg::REQ_ALLOC) |=>
      (state_r == fba_pkg::S_SCAN || state_r == fba_pkg::S_RESPOND))
    else $error("Alloc did not go to scan or respond.");

  a_rsp_from_respond: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fba_pkg::S_RESPOND))
    else $error("Response raised outside the respond state.");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_present_r) |-> (out_status_r == fba_pkg::ST_OK && !out_used_r))
    else $error("Present page entry with a failing status.");
`endif

endmodule
